// File: rtl/lbr_pkg.sv
package lbr_pkg;

  // fixed sizes of the datapath
  localparam int unsigned BLOCK_LEN_DEF = 128;
  localparam int unsigned PHASES_DEF    = 64;
  localparam int unsigned TAPS          = 8;
  localparam int unsigned HIST_DEPTH    = 8;
  localparam int unsigned LOBES         = 3;
  localparam int unsigned SMP_W         = 16;
  localparam int unsigned WGT_W         = 16;
  localparam int unsigned PROD_W        = 32;
  localparam int unsigned SUM_W         = 35;
  localparam int unsigned WSUM_W        = 19;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned IRATE_W       = 18;
  localparam int unsigned ORATE_W       = 16;
  localparam int unsigned AGE_W         = 3;
  localparam int unsigned DIST_W        = 10;

  // shared divider
  localparam int unsigned NUM_W   = 36;
  localparam int unsigned DEN_W   = 20;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned QB_W    = 5;
  localparam logic [QB_W-1:0] STEP_QB = 5'd5;
  localparam logic [QB_W-1:0] RND_QB  = 5'd16;

  // rate limits
  localparam logic [IRATE_W-1:0] IN_RATE_MIN  = 18'd8000;
  localparam logic [IRATE_W-1:0] IN_RATE_MAX  = 18'd192000;
  localparam logic [ORATE_W-1:0] OUT_RATE_MIN = 16'd8000;
  localparam logic [ORATE_W-1:0] OUT_RATE_MAX = 16'd64000;

  // register map, word index
  localparam logic [1:0] REG_INPUT_RATE  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_RATE = 2'd1;
  localparam logic [1:0] REG_MONO_INPUT  = 2'd2;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam longint      ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic                    block_end;
  } lbr_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_left;
    logic signed [SMP_W-1:0] out_right;
    logic                    block_done;
    logic                    run_last;
  } lbr_out_t;

  typedef logic [TAPS-1:0][WGT_W-1:0] lbr_row_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_l;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [WGT_W-1:0]  wt;
  } lbr_lane_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  sl;
    logic signed [SUM_W-1:0]  sr;
    logic signed [WSUM_W-1:0] w;
  } lbr_sum_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [QB_W-1:0]  qbits;
  } lbr_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } lbr_div_rsp_t;

  // elaboration-time arithmetic for the kernel table

  function automatic logic [63:0] lbr_udiv(input logic [63:0] a, input logic [63:0] b,
                                           input logic want_rem);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return want_rem ? r[63:0] : q;
  endfunction

  function automatic longint lbr_sin_quadrant(input logic [63:0] x);
    longint      sum;
    logic [63:0] term;
    sum  = longint'(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = lbr_udiv(term, 64'((2 * n) * (2 * n + 1)), 1'b0);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic longint lbr_sin_pi_ratio(input logic [63:0] s, input logic [63:0] n);
    logic [63:0] r;
    logic        neg;
    logic [63:0] theta;
    longint      v;
    r   = lbr_udiv(s, n << 1, 1'b1);
    neg = (r >= n);
    if (neg) r = r - n;
    if ((r << 1) > n) r = n - r;
    theta = lbr_udiv(PI_Q30 * r + (n >> 1), n, 1'b0);
    v     = lbr_sin_quadrant(theta);
    return neg ? -v : v;
  endfunction

  function automatic longint lbr_sinc(input logic [63:0] s, input logic [63:0] n);
    logic [63:0] x;
    logic [63:0] mag;
    logic [63:0] q;
    longint      v;
    if (s == 0) return ONE_Q30;
    x   = lbr_udiv(PI_Q30 * s + (n >> 1), n, 1'b0);
    v   = lbr_sin_pi_ratio(s, n);
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q   = lbr_udiv((mag << 30) + (x >> 1), x, 1'b0);
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [WGT_W-1:0] lbr_kernel(input int p, input int k, input int phases);
    int          t;
    int          at;
    longint      prod;
    logic [63:0] mag;
    logic [63:0] q;
    logic [WGT_W-1:0] val;
    t   = int'(LOBES) * phases + p - k * phases;
    at  = (t < 0) ? -t : t;
    val = '0;
    if (at < int'(LOBES) * phases) begin
      prod = lbr_sinc(64'(at), 64'(phases)) * lbr_sinc(64'(at), 64'(int'(LOBES) * phases));
      mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
      q    = (mag + (64'd1 << 44)) >> 45;
      if (q > 64'd32767) q = 64'd32767;
      val = (prod < 0) ? WGT_W'(-q) : WGT_W'(q);
    end
    return val;
  endfunction

endpackage

// File: rtl/lbr_div.sv
module lbr_div
  import lbr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lbr_div_req_t req,
  output lbr_div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic [QB_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             ovf_r, ovf_nxt;

  logic [NUM_W-1:0] head;
  logic [DEN_W:0]   trial;
  logic [5:0]       bit_idx;
  logic             fin;

  assign fin     = busy_r && (cnt_r == '0);
  assign bit_idx = {1'b0, cnt_r - 5'd1};
  assign trial   = {rem_r, num_r[bit_idx]};
  assign head    = req.num >> req.qbits;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.qbits;
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = DEN_W'(head);
      quo_nxt  = '0;
      ovf_nxt  = (head >= NUM_W'(req.den));
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      // one restoring step per cycle
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = DEN_W'(trial);
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = fin;
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/lbr_lane.sv
module lbr_lane
  import lbr_pkg::*;
(
  input  logic                     clk,
  input  logic [AGE_W-1:0]         age,
  input  logic signed [DIST_W-1:0] tap_off,
  input  logic [CNT_W-1:0]         m_idx,
  input  lbr_row_t                 row,
  input  logic signed [SMP_W-1:0]  smp_l,
  input  logic signed [SMP_W-1:0]  smp_r,
  output lbr_lane_t                res
);

  logic signed [DIST_W-1:0] tap;
  logic                     hit;
  logic signed [WGT_W-1:0]  wt;
  lbr_lane_t                res_r;

  // tap of the kernel that this history slot falls on
  assign tap = tap_off - $signed({{(DIST_W-AGE_W){1'b0}}, age});
  assign hit = (tap >= 0) && (tap <= $signed(DIST_W'(TAPS - 1)))
             && ({{(CNT_W-AGE_W){1'b0}}, age} <= m_idx);
  assign wt  = hit ? $signed(row[tap[AGE_W-1:0]]) : '0;

  always_ff @(posedge clk) begin
    res_r.prod_l <= wt * smp_l;
    res_r.prod_r <= wt * smp_r;
    res_r.wt     <= wt;
  end

  assign res = res_r;

endmodule

// File: rtl/lbr_merge.sv
module lbr_merge
  import lbr_pkg::*;
(
  input  logic      clk,
  input  lbr_lane_t lanes [HIST_DEPTH],
  output lbr_sum_t  sums
);

  lbr_sum_t acc;
  lbr_sum_t sums_r;

  always_comb begin
    acc = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      acc.sl = acc.sl + SUM_W'(lanes[i].prod_l);
      acc.sr = acc.sr + SUM_W'(lanes[i].prod_r);
      acc.w  = acc.w + WSUM_W'(lanes[i].wt);
    end
  end

  always_ff @(posedge clk) begin
    sums_r <= acc;
  end

  assign sums = sums_r;

endmodule

// File: rtl/lanczos_block_resampler_core.sv
// lanczos a=3 sample-rate converter for stereo 16-bit audio
// in_*  : one stereo sample pair per transaction, block_end closes a block
//         (a block also closes itself after BLOCK_LEN samples)
// out_* : resampled stereo pairs; run_last marks the last pair caused by an
//         input transaction, block_done the last pair of a closed block
// cfg_* : apb-style write/read port, source rate at 0x0, target rate at 0x4,
//         mono_input at 0x8; write only while the block is idle
// one input transaction is worked on at a time: in_stall stays high from the
// accepting edge until every result of it has been placed in the output
// register. per item the shared bit-serial divider works out the step, then per
// result the phase index and the left and right normalisation, at one quotient
// bit per cycle
// out_stall holds the output register; the sequencer waits on it and the
// pending result stays put, nothing is dropped
// reset (rst_n low at a clock edge) restores the default rates, clears the
// sample history, the block counter and the phase accumulator
module lanczos_block_resampler_core
  import lbr_pkg::*;
#(
  parameter int unsigned BLOCK_LEN = BLOCK_LEN_DEF,
  parameter int unsigned PHASES    = PHASES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  lbr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output lbr_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned PHASE_W = $clog2(PHASES);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STEP  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_PIDX  = 4'd3;
  localparam logic [3:0] S_ROW   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_RND   = 4'd7;
  localparam logic [3:0] S_DIVL  = 4'd8;
  localparam logic [3:0] S_DIVR  = 4'd9;
  localparam logic [3:0] S_ADV   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  // kernel table, one row of taps per phase
  lbr_row_t kern [PHASES];
  for (genvar gp = 0; gp < PHASES; gp++) begin : g_ph
    for (genvar gk = 0; gk < TAPS; gk++) begin : g_tap
      localparam logic [WGT_W-1:0] KV = lbr_kernel(gp, gk, PHASES);
      assign kern[gp][gk] = KV;
    end
  end

  // configuration registers
  logic [IRATE_W-1:0] in_rate_r;
  logic [ORATE_W-1:0] out_rate_r;
  logic               mono_r;
  logic               cfg_wr;
  logic [IRATE_W-1:0] rin_c;
  logic [ORATE_W-1:0] rout_c;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rate_r  <= 18'd44100;
      out_rate_r <= 16'd48000;
      mono_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_INPUT_RATE:  in_rate_r  <= cfg_pwdata[IRATE_W-1:0];
        REG_OUTPUT_RATE: out_rate_r <= cfg_pwdata[ORATE_W-1:0];
        REG_MONO_INPUT:  mono_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_INPUT_RATE:  cfg_prdata = 32'(in_rate_r);
      REG_OUTPUT_RATE: cfg_prdata = 32'(out_rate_r);
      REG_MONO_INPUT:  cfg_prdata = 32'(mono_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // rates clamped to their legal ranges
  assign rin_c  = (in_rate_r < IN_RATE_MIN) ? IN_RATE_MIN :
                  (in_rate_r > IN_RATE_MAX) ? IN_RATE_MAX : in_rate_r;
  assign rout_c = (out_rate_r < OUT_RATE_MIN) ? OUT_RATE_MIN :
                  (out_rate_r > OUT_RATE_MAX) ? OUT_RATE_MAX : out_rate_r;

  // state
  logic [3:0]              state_r, state_nxt;
  logic signed [SMP_W-1:0] hist_l_r [HIST_DEPTH];
  logic signed [SMP_W-1:0] hist_r_r [HIST_DEPTH];
  logic [CNT_W-1:0]        block_cnt_r, block_cnt_nxt;
  logic [CNT_W-1:0]        phase_int_r, phase_int_nxt;
  logic [ORATE_W-1:0]      phase_rem_r, phase_rem_nxt;
  logic [CNT_W-1:0]        m_r, m_nxt;
  logic                    end_r, end_nxt;
  logic [QB_W-1:0]         step_int_r, step_int_nxt;
  logic [ORATE_W-1:0]      step_rem_r, step_rem_nxt;
  logic [PHASE_W-1:0]      p_r, p_nxt;
  lbr_row_t                row_r;
  logic signed [SMP_W-1:0] res_l_r, res_l_nxt;
  logic signed [SMP_W-1:0] res_r_r, res_r_nxt;
  logic                    out_valid_r, out_valid_nxt;
  lbr_out_t                out_data_r, out_data_nxt;

  logic                    accept;
  logic [CNT_W-1:0]        m_in;
  logic                    more;
  logic                    can_load;
  logic signed [DIST_W-1:0] tap_off;
  logic [ORATE_W:0]        rem_sum;
  logic                    wrap;
  logic [CNT_W:0]          nf;
  lbr_div_req_t            div_req;
  lbr_div_rsp_t            div_rsp;
  lbr_lane_t               lane_res [HIST_DEPTH];
  lbr_sum_t                sums;
  logic [SUM_W-1:0]        mag_l, mag_r;
  logic signed [SMP_W-1:0] rnd_q;
  logic                    rnd_neg;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_load  = !out_valid_r || !out_stall;

  assign m_in = (block_cnt_r >= CNT_W'(BLOCK_LEN)) ? CNT_W'(BLOCK_LEN - 1) : block_cnt_r;

  // another output of this step is due at the current position
  assign more = end_r ? (phase_int_r <= m_r)
                      : ({1'b0, phase_int_r} + 9'd3 <= {1'b0, m_r});

  // distance from the output position back to the newest sample, plus lobes
  assign tap_off = $signed({2'b00, m_r}) + $signed(DIST_W'(LOBES))
                 - $signed({2'b00, phase_int_r});

  // position advance by one output period
  assign rem_sum = {1'b0, phase_rem_r} + {1'b0, step_rem_r};
  assign wrap    = (rem_sum >= {1'b0, rout_c});
  assign nf      = {1'b0, phase_int_r} + {4'b0000, step_int_r} + {8'd0, wrap};

  // magnitudes for the rounded normalisation
  assign mag_l = sums.sl[SUM_W-1] ? SUM_W'(-sums.sl) : SUM_W'(sums.sl);
  assign mag_r = sums.sr[SUM_W-1] ? SUM_W'(-sums.sr) : SUM_W'(sums.sr);

  // saturate the quotient with the sign of the sum under division
  assign rnd_neg = (state_r == S_DIVL) ? sums.sl[SUM_W-1] : sums.sr[SUM_W-1];
  always_comb begin
    if (rnd_neg) begin
      rnd_q = (div_rsp.ovf || div_rsp.quo > 16'd32768) ? 16'sh8000
                                                        : $signed(SMP_W'(~div_rsp.quo + 16'd1));
    end else begin
      rnd_q = (div_rsp.ovf || div_rsp.quo > 16'd32767) ? 16'sh7fff : $signed(div_rsp.quo);
    end
  end

  // divider requests
  always_comb begin
    div_req = '0;
    priority if (state_r == S_IDLE && accept) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_W'(rin_c);
      div_req.den   = DEN_W'(rout_c);
      div_req.qbits = STEP_QB;
    end else if ((state_r == S_CHECK && more) || (state_r == S_EMIT && can_load && more)) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_W'(phase_rem_r) * NUM_W'(PHASES);
      div_req.den   = DEN_W'(rout_c);
      div_req.qbits = QB_W'(PHASE_W);
    end else if (state_r == S_RND && sums.w > 0) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_W'({mag_l, 1'b0}) + NUM_W'(sums.w);
      div_req.den   = DEN_W'({sums.w, 1'b0});
      div_req.qbits = RND_QB;
    end else if (state_r == S_DIVL && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_W'({mag_r, 1'b0}) + NUM_W'(sums.w);
      div_req.den   = DEN_W'({sums.w, 1'b0});
      div_req.qbits = RND_QB;
    end else begin
      div_req = '0;
    end
  end

  lbr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // one lane per history slot
  for (genvar ga = 0; ga < HIST_DEPTH; ga++) begin : g_lane
    lbr_lane u_lane (
      .clk     (clk),
      .age     (AGE_W'(ga)),
      .tap_off (tap_off),
      .m_idx   (m_r),
      .row     (row_r),
      .smp_l   (hist_l_r[ga]),
      .smp_r   (hist_r_r[ga]),
      .res     (lane_res[ga])
    );
  end

  lbr_merge u_merge (
    .clk   (clk),
    .lanes (lane_res),
    .sums  (sums)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    block_cnt_nxt = block_cnt_r;
    phase_int_nxt = phase_int_r;
    phase_rem_nxt = phase_rem_r;
    m_nxt         = m_r;
    end_nxt       = end_r;
    step_int_nxt  = step_int_r;
    step_rem_nxt  = step_rem_r;
    p_nxt         = p_r;
    res_l_nxt     = res_l_r;
    res_r_nxt     = res_r_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          m_nxt   = m_in;
          end_nxt = in_data.block_end || ({1'b0, m_in} + 9'd1 >= 9'(BLOCK_LEN));
          // a rate change inside a block can leave the remainder too large
          if (phase_rem_r >= rout_c) phase_rem_nxt = rout_c - 16'd1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (div_rsp.done) begin
          step_int_nxt = div_rsp.quo[QB_W-1:0];
          step_rem_nxt = div_rsp.rem[ORATE_W-1:0];
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: state_nxt = more ? S_PIDX : S_FIN;
      S_PIDX: begin
        if (div_rsp.done) begin
          p_nxt     = div_rsp.quo[PHASE_W-1:0];
          state_nxt = S_ROW;
        end
      end
      S_ROW: state_nxt = S_MUL;
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_RND;
      S_RND: begin
        if (sums.w > 0) begin
          state_nxt = S_DIVL;
        end else begin
          res_l_nxt = '0;
          res_r_nxt = '0;
          state_nxt = S_ADV;
        end
      end
      S_DIVL: begin
        if (div_rsp.done) begin
          res_l_nxt = rnd_q;
          state_nxt = S_DIVR;
        end
      end
      S_DIVR: begin
        if (div_rsp.done) begin
          res_r_nxt = rnd_q;
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        phase_rem_nxt = wrap ? ORATE_W'(rem_sum - {1'b0, rout_c}) : ORATE_W'(rem_sum);
        phase_int_nxt = (nf > 9'd255) ? 8'd255 : nf[CNT_W-1:0];
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_left   = res_l_r;
          out_data_nxt.out_right  = res_r_r;
          out_data_nxt.run_last   = !more;
          out_data_nxt.block_done = !more && end_r;
          state_nxt               = more ? S_PIDX : S_FIN;
        end
      end
      S_FIN: begin
        if (end_r) begin
          block_cnt_nxt = '0;
          phase_int_nxt = '0;
          phase_rem_nxt = '0;
        end else begin
          block_cnt_nxt = m_r + 8'd1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      block_cnt_r <= '0;
      phase_int_r <= '0;
      phase_rem_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_l_r[i] <= '0;
        hist_r_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      block_cnt_r <= block_cnt_nxt;
      phase_int_r <= phase_int_nxt;
      phase_rem_r <= phase_rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
          hist_l_r[i] <= hist_l_r[i-1];
          hist_r_r[i] <= hist_r_r[i-1];
        end
        hist_l_r[0] <= in_data.left_sample;
        hist_r_r[0] <= mono_r ? in_data.left_sample : in_data.right_sample;
      end
    end
    m_r        <= m_nxt;
    end_r      <= end_nxt;
    step_int_r <= step_int_nxt;
    step_rem_r <= step_rem_nxt;
    p_r        <= p_nxt;
    res_l_r    <= res_l_nxt;
    res_r_r    <= res_r_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == S_ROW) row_r <= kern[p_r];
  end

  // checks
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.block_done |-> out_data.run_last)
    else $error("block_done without run_last");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && state_r != S_STEP |-> phase_rem_r < rout_c)
    else $error("phase remainder not below output rate");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy || div_rsp.done)
    else $error("divider restarted mid-operation");

endmodule

// File: test/testbench.sv
module testbench;
  import lbr_pkg::*;

  localparam int unsigned KERN_PHASES = 64;
  localparam int unsigned MAX_CYCLES  = 1000000;
  localparam int unsigned SETTLE      = 80;
  localparam longint unsigned PI_FIX  = 64'd3373259426;
  localparam longint ONE_FIX          = 64'sd1073741824;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  lbr_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  lbr_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lanczos_block_resampler_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // clock, period 20
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block: rates, mode, history and phase accumulator
  int          kern_w [KERN_PHASES][TAPS];
  int unsigned rate_in_reg;
  int unsigned rate_out_reg;
  bit          mono_reg;
  logic [15:0] hist_l [HIST_DEPTH];
  logic [15:0] hist_r [HIST_DEPTH];
  int unsigned samples_in_block;
  int unsigned pos_int;
  int unsigned pos_rem;

  lbr_out_t    expected_pairs[$];
  int          fail_count;
  int unsigned cycle_count;
  bit          no_idle;

  // sine on the first quadrant, q30 taylor series of 8 terms
  function automatic longint sine_quadrant(longint unsigned x);
    longint          acc;
    longint unsigned term;
    acc  = longint'(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > ONE_FIX) acc = ONE_FIX;
    return acc;
  endfunction

  // sin(pi * s / n) with exact quadrant folding
  function automatic longint sine_of_ratio(longint unsigned s, longint unsigned n);
    longint unsigned r;
    longint unsigned theta;
    bit              neg;
    longint          v;
    r   = s % (2 * n);
    neg = (r >= n);
    if (neg) r = r - n;
    if (2 * r > n) r = n - r;
    theta = (PI_FIX * r + n / 2) / n;
    v = sine_quadrant(theta);
    return neg ? -v : v;
  endfunction

  function automatic longint sinc_fix(longint unsigned s, longint unsigned n);
    longint unsigned x;
    longint unsigned mag;
    longint unsigned q;
    longint          v;
    if (s == 0) return ONE_FIX;
    x   = (PI_FIX * s + n / 2) / n;
    v   = sine_of_ratio(s, n);
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q   = ((mag << 30) + x / 2) / x;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic build_kernel();
    int              t;
    int              at;
    longint          prod;
    longint unsigned mag;
    longint unsigned q;
    for (int p = 0; p < KERN_PHASES; p++) begin
      for (int k = 0; k < TAPS; k++) begin
        t  = LOBES * KERN_PHASES + p - k * KERN_PHASES;
        at = (t < 0) ? -t : t;
        kern_w[p][k] = 0;
        if (at < LOBES * KERN_PHASES) begin
          prod = sinc_fix(at, KERN_PHASES) * sinc_fix(at, LOBES * KERN_PHASES);
          mag  = (prod < 0) ? longint'(-prod) : longint'(prod);
          q    = (mag + (64'd1 << 44)) >> 45;
          if (q > 32767) q = 32767;
          kern_w[p][k] = (prod < 0) ? -int'(q) : int'(q);
        end
      end
    end
  endtask

  // normalise by the weight sum, round half away from zero, saturate
  function automatic logic [15:0] normalise(longint acc, longint wsum);
    longint unsigned mag;
    longint unsigned q;
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    q   = (2 * mag + wsum) / (2 * wsum);
    if (acc < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  // works out every output pair caused by one input transaction
  task automatic resample_item(lbr_in_t item);
    int unsigned rin;
    int unsigned rout;
    int unsigned step_int;
    int unsigned step_rem;
    int unsigned newest;
    int unsigned ph;
    int unsigned next_int;
    int          tap_pos;
    int          age;
    int          made;
    bit          closes;
    longint      acc_l;
    longint      acc_r;
    longint      wsum;
    lbr_out_t    res;
    rin  = (rate_in_reg < 8000) ? 8000 : ((rate_in_reg > 192000) ? 192000 : rate_in_reg);
    rout = (rate_out_reg < 8000) ? 8000 : ((rate_out_reg > 64000) ? 64000 : rate_out_reg);
    if (pos_rem >= rout) pos_rem = rout - 1;
    step_int = rin / rout;
    step_rem = rin % rout;
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      hist_l[i] = hist_l[i-1];
      hist_r[i] = hist_r[i-1];
    end
    hist_l[0] = item.left_sample;
    hist_r[0] = mono_reg ? item.left_sample : item.right_sample;
    newest = (samples_in_block >= BLOCK_LEN_DEF) ? BLOCK_LEN_DEF - 1 : samples_in_block;
    closes = item.block_end || (newest + 1 >= BLOCK_LEN_DEF);
    made = 0;
    while (made < 40) begin
      if (closes ? (pos_int > newest) : (pos_int + LOBES > newest)) break;
      ph    = (pos_rem * KERN_PHASES) / rout;
      acc_l = 0;
      acc_r = 0;
      wsum  = 0;
      for (int k = 0; k < TAPS; k++) begin
        tap_pos = int'(pos_int) - int'(LOBES) + k;
        age     = int'(newest) - tap_pos;
        if (tap_pos < 0 || age < 0 || age >= HIST_DEPTH) continue;
        acc_l += longint'(kern_w[ph][k]) * longint'($signed(hist_l[age]));
        acc_r += longint'(kern_w[ph][k]) * longint'($signed(hist_r[age]));
        wsum  += kern_w[ph][k];
      end
      res = '0;
      if (wsum > 0) begin
        res.out_left  = normalise(acc_l, wsum);
        res.out_right = normalise(acc_r, wsum);
      end
      expected_pairs.push_back(res);
      made++;
      pos_rem += step_rem;
      next_int = pos_int + step_int;
      if (pos_rem >= rout) begin
        pos_rem -= rout;
        next_int++;
      end
      pos_int = (next_int > 255) ? 255 : next_int;
    end
    if (made > 0) begin
      expected_pairs[$].run_last = 1'b1;
      if (closes) expected_pairs[$].block_done = 1'b1;
    end
    if (closes) begin
      samples_in_block = 0;
      pos_int = 0;
      pos_rem = 0;
    end else begin
      samples_in_block = newest + 1;
    end
  endtask

  // result side: random stall, none while no_idle is set
  always @(negedge clk) begin
    out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 38);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    lbr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, out_data);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_data.out_left !== want.out_left) begin
          $display("%0t: out_left expected %0d actual %0d", $time,
                   want.out_left, out_data.out_left);
          fail_count++;
        end
        if (out_data.out_right !== want.out_right) begin
          $display("%0t: out_right expected %0d actual %0d", $time,
                   want.out_right, out_data.out_right);
          fail_count++;
        end
        if (out_data.block_done !== want.block_done) begin
          $display("%0t: block_done expected %0b actual %0b", $time,
                   want.block_done, out_data.block_done);
          fail_count++;
        end
        if (out_data.run_last !== want.run_last) begin
          $display("%0t: run_last expected %0b actual %0b", $time,
                   want.run_last, out_data.run_last);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // send one sample pair; valid stays high between back-to-back transactions
  task automatic send_pair(logic [15:0] left, logic [15:0] right, bit last);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < 38) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.left_sample  = left;
    in_data.right_sample = right;
    in_data.block_end    = last;
    do @(posedge clk); while (in_stall);
    resample_item(in_data);
  endtask

  // wait until all results are in and the block has settled
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, setup then access phase, only called while idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_INPUT_RATE:  rate_in_reg  = value[17:0];
      REG_OUTPUT_RATE: rate_out_reg = value[15:0];
      REG_MONO_INPUT:  mono_reg     = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_rates(int unsigned rin, int unsigned rout, bit mono);
    write_reg(REG_INPUT_RATE, rin);
    write_reg(REG_OUTPUT_RATE, rout);
    write_reg(REG_MONO_INPUT, 32'(mono));
  endtask

  // full-scale samples, alternating signs, single-sample block, mono mode
  task automatic test_sample_extremes();
    send_pair(16'h7fff, 16'h8000, 1'b0);
    send_pair(16'h7fff, 16'h8000, 1'b0);
    send_pair(16'h8000, 16'h7fff, 1'b0);
    send_pair(16'h8000, 16'h7fff, 1'b0);
    send_pair(16'h0000, 16'hffff, 1'b0);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h1234, 16'hedcb, 1'b1);
    write_reg(REG_MONO_INPUT, 1);
    send_pair(16'h7fff, 16'h0001, 1'b0);
    send_pair(16'h8000, 16'h5555, 1'b0);
    send_pair(16'h4000, 16'haaaa, 1'b1);
    write_reg(REG_MONO_INPUT, 0);
  endtask

  // strongest up and down conversion, then register values out of range
  task automatic test_rate_extremes();
    set_rates(8000, 64000, 0);
    for (int i = 0; i < 4; i++) send_pair(16'($urandom), 16'($urandom), i == 3);
    // heavy decimation: a short block may end without any output
    set_rates(192000, 8000, 0);
    for (int i = 0; i < 3; i++) send_pair(16'($urandom), 16'($urandom), i == 2);
    set_rates(0, 16'hffff, 0);
    for (int i = 0; i < 3; i++) send_pair(16'($urandom), 16'($urandom), i == 2);
    set_rates(18'h3ffff, 0, 0);
    for (int i = 0; i < 3; i++) send_pair(16'($urandom), 16'($urandom), i == 2);
  endtask

  // lowering the output rate mid-block saturates the phase remainder
  task automatic test_rate_change_in_block();
    set_rates(44100, 63997, 0);
    send_pair(16'h0100, 16'hff00, 1'b0);
    send_pair(16'h7000, 16'h9000, 1'b0);
    send_pair(16'h0200, 16'hfe00, 1'b0);
    write_reg(REG_OUTPUT_RATE, 8000);
    send_pair(16'h0300, 16'hfd00, 1'b0);
    send_pair(16'h0400, 16'hfc00, 1'b1);
  endtask

  // random blocks under a spread of settings, one block filling up on its own
  task automatic test_random_blocks();
    int unsigned len;
    int unsigned sent;
    logic [15:0] l;
    logic [15:0] r;
    sent = 0;
    while (sent < 190) begin
      set_rates($urandom_range(6000, 200000), $urandom_range(6000, 65535),
                $urandom_range(0, 3) == 0);
      no_idle = ($urandom_range(0, 4) == 0);
      if (sent == 0) len = BLOCK_LEN_DEF + 2;
      else len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        l = 16'($urandom);
        r = 16'($urandom);
        if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        // the full block carries no end marker, the block closes itself
        send_pair(l, r, (len <= 14) && (i == len - 1));
      end
      sent += len;
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    fail_count   = 0;
    cycle_count  = 0;
    no_idle      = 1'b0;
    rate_in_reg  = 44100;
    rate_out_reg = 48000;
    mono_reg     = 1'b0;
    samples_in_block = 0;
    pos_int      = 0;
    pos_rem      = 0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
    build_kernel();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_sample_extremes();
    test_rate_extremes();
    test_rate_change_in_block();
    test_random_blocks();

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
